[hw/rtl/sacl_pkg.sv]
// ----------------------------------------------------------------------------
// sacl_pkg
// shared types and constants for the set-associative lru cache lookup
// ----------------------------------------------------------------------------
package sacl_pkg;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 4;

    typedef logic [CFG_IDX_W-1:0]  t_cfg_idx;
    typedef logic [CFG_DATA_W-1:0] t_cfg_val;

    localparam t_cfg_idx CFG_OFFSET_BITS = 2'd0;
    localparam t_cfg_idx CFG_INDEX_BITS  = 2'd1;
    localparam t_cfg_idx CFG_WAYS_USED   = 2'd2;

    localparam t_cfg_val RST_OFFSET_BITS = 4'd5;
    localparam t_cfg_val RST_INDEX_BITS  = 4'd6;
    localparam t_cfg_val RST_WAYS_USED   = 4'd4;

    typedef struct packed {
        t_cfg_val offset_bits;
        t_cfg_val index_bits;
        t_cfg_val ways_used;
    } t_cfg;

    // access kinds
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_STORE = 1'b1;

    // width of the way field in a result item
    localparam int WAY_OUT_W = 3;

endpackage

[hw/rtl/sacl_addr_split.sv]
// ----------------------------------------------------------------------------
// sacl_addr_split
// splits a byte address into set index and tag by the configured bit counts
// ----------------------------------------------------------------------------
module sacl_addr_split
    import sacl_pkg::*;
#(
    parameter int ADDR_BITS = 24,
    parameter int MAX_SETS  = 1024
) (
    input  logic [ADDR_BITS-1:0] i_address,
    input  t_cfg_val             i_offset_bits,
    input  t_cfg_val             i_index_bits,
    output logic [((MAX_SETS > 1) ? $clog2(MAX_SETS) : 1)-1:0] o_set,
    output logic [ADDR_BITS-1:0] o_tag
);

    localparam int SET_W  = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
    localparam int IB_MAX = $clog2(MAX_SETS + 1) - 1;
    localparam int EXT_W  = ADDR_BITS + SET_W;

    logic [ADDR_BITS-1:0] w_above;
    logic [EXT_W-1:0]     w_above_ext;
    logic [4:0]           w_ib_raw;
    logic [4:0]           w_ib;

    assign w_above     = i_address >> i_offset_bits;
    assign w_above_ext = {{SET_W{1'b0}}, w_above};
    assign w_ib_raw    = {1'b0, i_index_bits};

    // index width clamped to what the set count supports
    assign w_ib = (w_ib_raw > 5'(IB_MAX)) ? 5'(IB_MAX) : w_ib_raw;

    always_comb begin
        for (int i = 0; i < SET_W; i++) begin
            o_set[i] = w_above_ext[i] && (5'(i) < w_ib);
        end
    end

    assign o_tag = w_above >> w_ib;

endmodule

[hw/rtl/sacl_line_store.sv]
// ----------------------------------------------------------------------------
// sacl_line_store
// per-set tag and valid/stamp rows in two synchronous memories
// ----------------------------------------------------------------------------
module sacl_line_store
    import sacl_pkg::*;
#(
    parameter int ADDR_BITS  = 24,
    parameter int MAX_WAYS   = 8,
    parameter int MAX_SETS   = 1024,
    parameter int STAMP_BITS = 32
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_rd_en,
    input  logic [((MAX_SETS > 1) ? $clog2(MAX_SETS) : 1)-1:0] i_rd_set,
    input  logic                                 i_wr_en,
    input  logic                                 i_wr_tag_en,
    input  logic [((MAX_SETS > 1) ? $clog2(MAX_SETS) : 1)-1:0] i_wr_set,
    input  logic [((MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1)-1:0] i_wr_way,
    input  logic [ADDR_BITS-1:0]                 i_wr_tag,
    input  logic [STAMP_BITS-1:0]                i_wr_stamp,
    input  logic                                 i_clr_en,
    input  logic [((MAX_SETS > 1) ? $clog2(MAX_SETS) : 1)-1:0] i_clr_set,
    output logic [MAX_WAYS-1:0]                  o_valid_row,
    output logic [MAX_WAYS-1:0][STAMP_BITS-1:0]  o_stamp_row,
    output logic [MAX_WAYS-1:0][ADDR_BITS-1:0]   o_tag_row
);

    localparam int SET_W  = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
    localparam int META_W = MAX_WAYS * (STAMP_BITS + 1);
    localparam int TAG_W  = MAX_WAYS * ADDR_BITS;

    logic [META_W-1:0] r_meta_mem [MAX_SETS];
    logic [TAG_W-1:0]  r_tag_mem  [MAX_SETS];

    logic [META_W-1:0] r_meta_q;
    logic [TAG_W-1:0]  r_tag_q;
    logic              r_byp_meta;
    logic              r_byp_tag;
    logic [META_W-1:0] r_byp_meta_row;
    logic [TAG_W-1:0]  r_byp_tag_row;

    logic [MAX_WAYS-1:0]                 w_valid_new;
    logic [MAX_WAYS-1:0][STAMP_BITS-1:0] w_stamp_new;
    logic [MAX_WAYS-1:0][ADDR_BITS-1:0]  w_tag_new;
    logic                                w_meta_we;
    logic [SET_W-1:0]                    w_meta_wa;
    logic [META_W-1:0]                   w_meta_wd;

    // read data, with the row written at the read edge forwarded
    always_comb begin
        {o_valid_row, o_stamp_row} = r_byp_meta ? r_byp_meta_row : r_meta_q;
        o_tag_row                  = r_byp_tag  ? r_byp_tag_row  : r_tag_q;
    end

    // merge the updated way into the row held from this item's read
    always_comb begin
        w_valid_new           = o_valid_row;
        w_stamp_new           = o_stamp_row;
        w_tag_new             = o_tag_row;
        w_valid_new[i_wr_way] = 1'b1;
        w_stamp_new[i_wr_way] = i_wr_stamp;
        w_tag_new[i_wr_way]   = i_wr_tag;
    end

    assign w_meta_we = i_clr_en || i_wr_en;
    assign w_meta_wa = i_clr_en ? i_clr_set : i_wr_set;
    assign w_meta_wd = i_clr_en ? '0 : {w_valid_new, w_stamp_new};

    always_ff @(posedge i_clk) begin
        if (w_meta_we) begin
            r_meta_mem[w_meta_wa] <= w_meta_wd;
        end
        if (i_rd_en) begin
            r_meta_q <= r_meta_mem[i_rd_set];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_tag_en) begin
            r_tag_mem[i_wr_set] <= w_tag_new;
        end
        if (i_rd_en) begin
            r_tag_q <= r_tag_mem[i_rd_set];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_byp_meta_row <= w_meta_wd;
            r_byp_tag_row  <= w_tag_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byp_meta <= 1'b0;
            r_byp_tag  <= 1'b0;
        end else if (i_rd_en) begin
            r_byp_meta <= w_meta_we && (w_meta_wa == i_rd_set);
            r_byp_tag  <= i_wr_tag_en && (i_wr_set == i_rd_set);
        end
    end

endmodule

[hw/rtl/sacl_way_sel.sv]
// ----------------------------------------------------------------------------
// sacl_way_sel
// tag compare and lru victim choice over one set row, two stages
// ----------------------------------------------------------------------------
module sacl_way_sel
    import sacl_pkg::*;
#(
    parameter int ADDR_BITS  = 24,
    parameter int MAX_WAYS   = 8,
    parameter int STAMP_BITS = 32
) (
    input  logic                                i_clk,
    input  logic                                i_load,
    input  logic [MAX_WAYS-1:0]                 i_way_mask,
    input  logic [ADDR_BITS-1:0]                i_tag,
    input  logic [MAX_WAYS-1:0]                 i_valid_row,
    input  logic [MAX_WAYS-1:0][STAMP_BITS-1:0] i_stamp_row,
    input  logic [MAX_WAYS-1:0][ADDR_BITS-1:0]  i_tag_row,
    output logic                                o_hit,
    output logic [((MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1)-1:0] o_hit_way,
    output logic [((MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1)-1:0] o_vic_way
);

    localparam int WAY_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;

    logic [MAX_WAYS-1:0]                w_hit_vec;
    logic [WAY_W-1:0]                   w_hit_way;
    logic [MAX_WAYS-1:0][MAX_WAYS-1:0]  w_beat;
    logic [MAX_WAYS-1:0]                w_cand;

    logic                               r_hit;
    logic [WAY_W-1:0]                   r_hit_way;
    logic [MAX_WAYS-1:0][MAX_WAYS-1:0]  r_beat;

    // first stage: tag match per way, lowest matching way wins
    always_comb begin
        w_hit_way = '0;
        for (int w = 0; w < MAX_WAYS; w++) begin
            w_hit_vec[w] = i_way_mask[w] && i_valid_row[w] && (i_tag_row[w] == i_tag);
        end
        for (int w = MAX_WAYS - 1; w >= 0; w--) begin
            if (w_hit_vec[w]) begin
                w_hit_way = WAY_W'(w);
            end
        end
    end

    // w_beat[w][v]: way v has an older stamp than way w, ties to the lower way
    always_comb begin
        for (int w = 0; w < MAX_WAYS; w++) begin
            for (int v = 0; v < MAX_WAYS; v++) begin
                if (v == w) begin
                    w_beat[w][v] = 1'b0;
                end else if (v < w) begin
                    w_beat[w][v] = i_way_mask[v] && (i_stamp_row[v] <= i_stamp_row[w]);
                end else begin
                    w_beat[w][v] = i_way_mask[v] && (i_stamp_row[v] < i_stamp_row[w]);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_hit     <= |w_hit_vec;
            r_hit_way <= w_hit_way;
            r_beat    <= w_beat;
        end
    end

    // second stage: the one in-use way that nothing beats
    always_comb begin
        o_vic_way = '0;
        for (int w = 0; w < MAX_WAYS; w++) begin
            w_cand[w] = i_way_mask[w] && !(|r_beat[w]);
            if (w_cand[w]) begin
                o_vic_way = o_vic_way | WAY_W'(w);
            end
        end
    end

    assign o_hit     = r_hit;
    assign o_hit_way = r_hit_way;

endmodule

[hw/rtl/set_assoc_cache_lru_lookup.sv]
// ----------------------------------------------------------------------------
// set_assoc_cache_lru_lookup
// set-associative cache tag lookup with lru replacement, no allocate on store
// ----------------------------------------------------------------------------
// usage
//   input channel (i_valid/o_ready) carries one access: i_op (load or store)
//   and the byte address i_address. the output channel (o_valid/i_ready)
//   returns one item per access: o_hit, o_filled, o_way_hit_or_filled.
//   the config channel (i_cfg_valid/o_cfg_ready) writes offset_bits,
//   index_bits and ways_used by index; it is always ready and must be used
//   only while no access is in flight.
//   a new access is taken only while idle or as the previous one retires
//   at write-back, set by the read-modify-write of the set row: the memory
//   read, then the compare and victim pick, with the write-back overlapping
//   the next access's read. after reset a clearing pass zeroes the valid
//   bits and stamps of every set, one set per cycle, and o_ready stays low
//   until the pass is through.
//   a stalled receiver holds the result in the output register; the block
//   still takes a new access, which then waits at write-back until the
//   output register is free.
// ----------------------------------------------------------------------------
module set_assoc_cache_lru_lookup
    import sacl_pkg::*;
#(
    parameter int ADDR_BITS  = 24,
    parameter int MAX_WAYS   = 8,
    parameter int MAX_SETS   = 1024,
    parameter int STAMP_BITS = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // access items
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic                 i_op,
    input  logic [ADDR_BITS-1:0] i_address,
    // result items
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic                 o_hit,
    output logic                 o_filled,
    output logic [WAY_OUT_W-1:0] o_way_hit_or_filled,
    // configuration writes
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  t_cfg_idx             i_cfg_index,
    input  t_cfg_val             i_cfg_data
);

    localparam int SET_W = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
    localparam int WAY_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;

    // item phase
    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_LOOK = 2'd1;   // set row arriving from memory
    localparam logic [1:0] PH_DONE = 2'd2;   // victim known, write back

    t_cfg                  r_cfg;
    logic [1:0]            r_phase;
    logic [1:0]            n_phase;
    logic                  r_clr_busy;
    logic [SET_W-1:0]      r_clr_set;
    logic [STAMP_BITS-1:0] r_clock;
    logic [ADDR_BITS-1:0]  r_tag;
    logic [SET_W-1:0]      r_set;
    logic                  r_store;
    logic                  r_out_valid;
    logic                  r_out_hit;
    logic                  r_out_filled;
    logic [WAY_OUT_W-1:0]  r_out_way;

    logic [SET_W-1:0]                    w_split_set;
    logic [ADDR_BITS-1:0]                w_split_tag;
    logic [4:0]                          w_ways_raw;
    logic [4:0]                          w_ways;
    logic [MAX_WAYS-1:0]                 w_way_mask;
    logic [MAX_WAYS-1:0]                 w_valid_row;
    logic [MAX_WAYS-1:0][STAMP_BITS-1:0] w_stamp_row;
    logic [MAX_WAYS-1:0][ADDR_BITS-1:0]  w_tag_row;
    logic                                w_hit;
    logic [WAY_W-1:0]                    w_hit_way;
    logic [WAY_W-1:0]                    w_vic_way;
    logic                                w_complete;
    logic                                w_accept;
    logic                                w_fill;
    logic [WAY_W-1:0]                    w_way;
    logic [WAY_W+WAY_OUT_W-1:0]          w_way_ext;

    // address split for the incoming access
    sacl_addr_split #(
        .ADDR_BITS (ADDR_BITS),
        .MAX_SETS  (MAX_SETS)
    ) u_split (
        .i_address     (i_address),
        .i_offset_bits (r_cfg.offset_bits),
        .i_index_bits  (r_cfg.index_bits),
        .o_set         (w_split_set),
        .o_tag         (w_split_tag)
    );

    // ways in use, clamped to one..MAX_WAYS
    assign w_ways_raw = {1'b0, r_cfg.ways_used};
    always_comb begin
        if (w_ways_raw == 5'd0) begin
            w_ways = 5'd1;
        end else if (w_ways_raw > 5'(MAX_WAYS)) begin
            w_ways = 5'(MAX_WAYS);
        end else begin
            w_ways = w_ways_raw;
        end
        for (int w = 0; w < MAX_WAYS; w++) begin
            w_way_mask[w] = 5'(w) < w_ways;
        end
    end

    // handshake: a new access may enter in the cycle the previous one retires
    assign w_complete  = (r_phase == PH_DONE) && (!r_out_valid || i_ready);
    assign o_ready     = !r_clr_busy && ((r_phase == PH_IDLE) || w_complete);
    assign w_accept    = i_valid && o_ready;
    assign o_cfg_ready = 1'b1;

    // load miss fills the lru way; store miss leaves the set alone
    assign w_fill = !w_hit && (r_store == OP_LOAD);
    assign w_way  = w_hit ? w_hit_way : (w_fill ? w_vic_way : '0);

    sacl_line_store #(
        .ADDR_BITS  (ADDR_BITS),
        .MAX_WAYS   (MAX_WAYS),
        .MAX_SETS   (MAX_SETS),
        .STAMP_BITS (STAMP_BITS)
    ) u_store (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rd_en     (w_accept),
        .i_rd_set    (w_split_set),
        .i_wr_en     (w_complete && (w_hit || w_fill)),
        .i_wr_tag_en (w_complete && w_fill),
        .i_wr_set    (r_set),
        .i_wr_way    (w_way),
        .i_wr_tag    (r_tag),
        .i_wr_stamp  (r_clock),
        .i_clr_en    (r_clr_busy),
        .i_clr_set   (r_clr_set),
        .o_valid_row (w_valid_row),
        .o_stamp_row (w_stamp_row),
        .o_tag_row   (w_tag_row)
    );

    sacl_way_sel #(
        .ADDR_BITS  (ADDR_BITS),
        .MAX_WAYS   (MAX_WAYS),
        .STAMP_BITS (STAMP_BITS)
    ) u_sel (
        .i_clk       (i_clk),
        .i_load      (r_phase == PH_LOOK),
        .i_way_mask  (w_way_mask),
        .i_tag       (r_tag),
        .i_valid_row (w_valid_row),
        .i_stamp_row (w_stamp_row),
        .i_tag_row   (w_tag_row),
        .o_hit       (w_hit),
        .o_hit_way   (w_hit_way),
        .o_vic_way   (w_vic_way)
    );

    // phase sequencing
    always_comb begin
        n_phase = r_phase;
        unique case (r_phase)
            PH_IDLE: begin
                if (w_accept) begin
                    n_phase = PH_LOOK;
                end
            end
            PH_LOOK: begin
                n_phase = PH_DONE;
            end
            PH_DONE: begin
                if (w_accept) begin
                    n_phase = PH_LOOK;
                end else if (w_complete) begin
                    n_phase = PH_IDLE;
                end
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase
    end

    // control state, config registers, access clock and clearing pass
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase           <= PH_IDLE;
            r_clr_busy        <= 1'b1;
            r_clr_set         <= '0;
            r_clock           <= '0;
            r_cfg.offset_bits <= RST_OFFSET_BITS;
            r_cfg.index_bits  <= RST_INDEX_BITS;
            r_cfg.ways_used   <= RST_WAYS_USED;
        end else begin
            r_phase <= n_phase;
            if (r_clr_busy) begin
                r_clr_set <= r_clr_set + 1'b1;
                if (r_clr_set == SET_W'(MAX_SETS - 1)) begin
                    r_clr_busy <= 1'b0;
                end
            end
            // every access ticks the clock, store misses too
            if (w_accept) begin
                r_clock <= r_clock + 1'b1;
            end
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_OFFSET_BITS: r_cfg.offset_bits <= i_cfg_data;
                    CFG_INDEX_BITS:  r_cfg.index_bits  <= i_cfg_data;
                    CFG_WAYS_USED:   r_cfg.ways_used   <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    // access held while in flight
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_tag   <= w_split_tag;
            r_set   <= w_split_set;
            r_store <= i_op;
        end
    end

    // output register
    assign w_way_ext = {{WAY_OUT_W{1'b0}}, w_way};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_complete) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_complete) begin
            r_out_hit    <= w_hit;
            r_out_filled <= w_fill;
            r_out_way    <= w_way_ext[WAY_OUT_W-1:0];
        end
    end

    assign o_valid             = r_out_valid;
    assign o_hit               = r_out_hit;
    assign o_filled            = r_out_filled;
    assign o_way_hit_or_filled = r_out_way;

endmodule
